FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros. Each check can be compiled out as a group.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hdl/aob_pkg.sv
// ----------------------------------------------------------------------------
// aob_pkg
// Types and constants shared by the source-over blend pipeline.
// ----------------------------------------------------------------------------
package aob_pkg;

	localparam int ChanW    = 8;   // one color or alpha channel
	localparam int CovW     = 16;  // combined coverage, up to 255*255
	localparam int NumW     = 24;  // weighted color sum, below 256*coverage
	localparam int NumLanes = 3;   // red, green, blue
	localparam int DivSteps = ChanW; // one quotient bit per stage
	localparam int LaneRed   = 0;
	localparam int LaneGreen = 1;
	localparam int LaneBlue  = 2;

	// x/255 == (x * 0x8081) >> 23 for every 16-bit x
	localparam logic [CovW-1:0] Recip255 = 16'h8081;
	localparam int RecipShift = 23;
	localparam int RecipW     = 2 * CovW;

	localparam logic [ChanW-1:0] ChanMax = 8'hFF;

	typedef struct packed {
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
		logic [ChanW-1:0] alpha;
	} pixel_t;

	// Payload carried through the divider stages
	typedef struct packed {
		logic [NumLanes-1:0][NumW-1:0]  rem;
		logic [NumLanes-1:0][ChanW-1:0] quo;
		logic [CovW-1:0]                cov;
		logic [ChanW-1:0]               oa;
		pixel_t                         byp;
		logic                           use_div;
	} div_t;

endpackage

FILE: hdl/aob_div_step.sv
// ----------------------------------------------------------------------------
// aob_div_step
// One registered restoring-division step for the three color lanes.
// Divisor is coverage<<7; the partial remainder shifts left each step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aob_div_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  aob_pkg::div_t in_data,
	output logic          out_valid,
	output aob_pkg::div_t out_data
);

	localparam int DivW = aob_pkg::NumW - 1;

	logic [DivW-1:0]          dvs;
	aob_pkg::div_t            nxt;
	logic                     valid_s1;
	aob_pkg::div_t            data_s1;

	assign dvs = {in_data.cov, (DivW - aob_pkg::CovW)'(0)};

	// compare-subtract per lane, shift in one quotient bit
	always_comb begin
		logic                         ge;
		logic [aob_pkg::NumW-1:0]     diff;
		nxt = in_data;
		for (int i = 0; i < aob_pkg::NumLanes; i++) begin
			ge   = in_data.rem[i] >= {1'b0, dvs};
			diff = in_data.rem[i] - {1'b0, dvs};
			if (ge) begin
				nxt.rem[i] = {diff[DivW-1:0], 1'b0};
			end else begin
				nxt.rem[i] = {in_data.rem[i][DivW-1:0], 1'b0};
			end
			nxt.quo[i] = {in_data.quo[i][aob_pkg::ChanW-2:0], ge};
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	// partial remainder stays below twice the divisor
	`ASSERT_IMPLIES(a_rem_red, clk, arst_n, valid_s1 && data_s1.use_div,
		data_s1.rem[aob_pkg::LaneRed] < {data_s1.cov, 8'h00}, "red remainder out of range")
	`ASSERT_IMPLIES(a_rem_green, clk, arst_n, valid_s1 && data_s1.use_div,
		data_s1.rem[aob_pkg::LaneGreen] < {data_s1.cov, 8'h00}, "green remainder out of range")
	`ASSERT_IMPLIES(a_rem_blue, clk, arst_n, valid_s1 && data_s1.use_div,
		data_s1.rem[aob_pkg::LaneBlue] < {data_s1.cov, 8'h00}, "blue remainder out of range")

endmodule

FILE: hdl/alpha_over_blend_unit.sv
// Depth: 12 register stages (S1, S2, S3, the divider stages S4..S11, S12) from input to output.
// Throughput: one pixel per cycle unless the output stalls; the quotient is formed
// one bit per stage over eight divider stages, so every stage holds a different pixel.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// alpha_over_blend_unit
// Source-over compositing of two straight-alpha RGBA8888 pixels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alpha_over_blend_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] dst_red,
	input  logic [7:0] dst_green,
	input  logic [7:0] dst_blue,
	input  logic [7:0] dst_alpha,
	input  logic [7:0] src_red,
	input  logic [7:0] src_green,
	input  logic [7:0] src_blue,
	input  logic [7:0] src_opacity,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	output logic [7:0] out_alpha
);

	localparam int ChanW = aob_pkg::ChanW;
	localparam int CovW  = aob_pkg::CovW;
	localparam int NumW  = aob_pkg::NumW;
	localparam int Lanes = aob_pkg::NumLanes;

	logic adv;

	logic                                valid_s1, valid_s2, valid_s3, valid_s12;
	aob_pkg::pixel_t                     dst_s1, src_s1;
	logic [CovW-1:0]                     sw_s1, dw_s1;
	logic                                pass_dst_s1, pass_src_s1;

	logic [Lanes-1:0][NumW-1:0]          prod_s_s2, prod_d_s2;
	logic [CovW-1:0]                     cov_s2;
	logic [CovW-1:0]                     cov_s2_d;
	aob_pkg::pixel_t                     byp_s2;
	logic                                use_div_s2;

	aob_pkg::div_t                       div_s3;
	aob_pkg::pixel_t                     pix_s12;

	logic                                div_vld [0:aob_pkg::DivSteps];
	aob_pkg::div_t                       div_data [0:aob_pkg::DivSteps];

	// whole pipeline moves unless the output holds an untaken result
	assign adv      = !valid_s12 || out_ready;
	assign in_ready = adv;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s12 <= 1'b0;
		end else if (adv) begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s12 <= div_vld[aob_pkg::DivSteps];
		end
	end

	// S1: weights sa*255 and da*(255-sa), special-case flags
	always_ff @(posedge clk) begin
		if (adv) begin
			dst_s1      <= '{red: dst_red, green: dst_green, blue: dst_blue, alpha: dst_alpha};
			src_s1      <= '{red: src_red, green: src_green, blue: src_blue, alpha: src_opacity};
			sw_s1       <= {src_opacity, 8'h00} - {8'h00, src_opacity};
			dw_s1       <= CovW'(dst_alpha) * CovW'(aob_pkg::ChanMax - src_opacity);
			pass_dst_s1 <= src_opacity == '0;
			pass_src_s1 <= src_opacity == aob_pkg::ChanMax;
		end
	end

	// S2: per-lane products, coverage, bypass pixel
	always_comb begin
		logic [CovW:0] cov_w;
		cov_w = {1'b0, sw_s1} + {1'b0, dw_s1};
		cov_s2_d = cov_w[CovW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s_s2[aob_pkg::LaneRed]   <= NumW'(src_s1.red)   * NumW'(sw_s1);
			prod_s_s2[aob_pkg::LaneGreen] <= NumW'(src_s1.green) * NumW'(sw_s1);
			prod_s_s2[aob_pkg::LaneBlue]  <= NumW'(src_s1.blue)  * NumW'(sw_s1);
			prod_d_s2[aob_pkg::LaneRed]   <= NumW'(dst_s1.red)   * NumW'(dw_s1);
			prod_d_s2[aob_pkg::LaneGreen] <= NumW'(dst_s1.green) * NumW'(dw_s1);
			prod_d_s2[aob_pkg::LaneBlue]  <= NumW'(dst_s1.blue)  * NumW'(dw_s1);
			cov_s2     <= cov_s2_d;
			use_div_s2 <= !pass_dst_s1 && !pass_src_s1 && (cov_s2_d != '0);
			priority if (pass_dst_s1) begin
				byp_s2 <= dst_s1;
			end else if (pass_src_s1) begin
				byp_s2 <= src_s1;
			end else begin
				byp_s2 <= '0;
			end
		end
	end

	// S3: numerators and output alpha (coverage / 255 by reciprocal)
	always_ff @(posedge clk) begin
		logic [NumW:0]        num_w;
		logic [aob_pkg::RecipW-1:0] oa_w;
		if (adv) begin
			for (int i = 0; i < Lanes; i++) begin
				num_w = {1'b0, prod_s_s2[i]} + {1'b0, prod_d_s2[i]};
				div_s3.rem[i] <= num_w[NumW-1:0];
				div_s3.quo[i] <= '0;
			end
			oa_w = aob_pkg::RecipW'(cov_s2) * aob_pkg::RecipW'(aob_pkg::Recip255);
			div_s3.oa      <= oa_w[aob_pkg::RecipShift +: ChanW];
			div_s3.cov     <= cov_s2;
			div_s3.byp     <= byp_s2;
			div_s3.use_div <= use_div_s2;
		end
	end

	// S4..S11: one quotient bit per stage
	assign div_vld[0]  = valid_s3;
	assign div_data[0] = div_s3;

	for (genvar g = 0; g < aob_pkg::DivSteps; g++) begin : g_div
		aob_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (div_vld[g]),
			.in_data   (div_data[g]),
			.out_valid (div_vld[g+1]),
			.out_data  (div_data[g+1])
		);
	end

	// S12: select blended or bypass pixel into the output register
	always_ff @(posedge clk) begin
		if (adv) begin
			if (div_data[aob_pkg::DivSteps].use_div) begin
				pix_s12 <= '{
					red:   div_data[aob_pkg::DivSteps].quo[aob_pkg::LaneRed],
					green: div_data[aob_pkg::DivSteps].quo[aob_pkg::LaneGreen],
					blue:  div_data[aob_pkg::DivSteps].quo[aob_pkg::LaneBlue],
					alpha: div_data[aob_pkg::DivSteps].oa
				};
			end else begin
				pix_s12 <= div_data[aob_pkg::DivSteps].byp;
			end
		end
	end

	assign out_valid = valid_s12;
	assign out_red   = pix_s12.red;
	assign out_green = pix_s12.green;
	assign out_blue  = pix_s12.blue;
	assign out_alpha = pix_s12.alpha;

	// an input transfer always lands in the first stage
	`ASSERT_NEXT(a_load_s1, clk, arst_n, in_valid && in_ready, valid_s1,
		"input transfer did not reach stage 1")
	// an idle advancing cycle leaves a bubble, never a stale item
	`ASSERT_NEXT(a_bubble_s1, clk, arst_n, !in_valid && in_ready, !valid_s1,
		"stage 1 valid without an input transfer")
	// the divider never sees a zero divisor
	`ASSERT_IMPLIES(a_cov_nonzero, clk, arst_n, valid_s2 && use_div_s2, cov_s2 != '0,
		"blend path selected with zero coverage")

endmodule
